/* hw/rtl/sao_blend_pkg.sv */
`default_nettype none

package sao_blend_pkg;

  // Width of one color or alpha channel.
  localparam int unsigned ChanW = 8;

  // Full-scale channel value: alpha 255 is fully opaque.
  localparam logic [ChanW-1:0] FullScale = 8'd255;

  // Blend numerator fc*fa*255 + bc*ba*(255-fa) stays below 2^25.
  localparam int unsigned NumW = 25;

  // Divisor 255*out_alpha stays below 2^16.
  localparam int unsigned DenW = 16;

  // One quotient bit per divider stage.
  localparam int unsigned DivSteps = ChanW;

  // Stages from the input transfer to the lane outputs: products, numerator,
  // divisor, saturation check, then the quotient bits.
  localparam int unsigned PipeDepth = 4 + DivSteps;

  // The blended alpha leaves its unit after two stages and then waits for the lanes.
  localparam int unsigned AlphaDelay = PipeDepth - 2;

  typedef struct packed {
    logic [ChanW-1:0] fg_red;
    logic [ChanW-1:0] fg_green;
    logic [ChanW-1:0] fg_blue;
    logic [ChanW-1:0] fg_alpha;
    logic [ChanW-1:0] bg_red;
    logic [ChanW-1:0] bg_green;
    logic [ChanW-1:0] bg_blue;
    logic [ChanW-1:0] bg_alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
  } result_t;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic             zero;
  } alpha_info_t;

  // Exact floor(x / 255) for any x up to 255 * 255.
  function automatic logic [ChanW-1:0] div255(input logic [2*ChanW-1:0] x);
    logic [2*ChanW:0] s;
    s = (2*ChanW+1)'(x) + (2*ChanW+1)'(x[2*ChanW-1:ChanW]) + (2*ChanW+1)'(1);
    return s[2*ChanW-1:ChanW];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/straight_alpha_over_blend_unit.sv */
`default_nettype none

// Straight-alpha Porter-Duff "over" compositor. Each transfer carries one
// foreground and one background pixel with unpremultiplied 8-bit alpha, and
// the block returns one blended pixel: alpha is fa + floor(ba*(255-fa)/255),
// each color channel is the weighted average of the two colors, floored and
// saturated at 255, and a blended alpha of zero gives an all-zero pixel. A new
// pixel is taken on every clock cycle: busy is high only while reset is held
// and in the first cycle after it is released. Every result appears on
// result_o with done_o high for exactly one cycle, in input order. The
// receiver cannot stall the block, so it must take every result in the cycle
// it is shown. The depth is set by the color lanes and the output register:
// two multiply stages build the numerator, one stage forms the divisor
// 255*alpha, one checks for saturation, and a pipelined restoring divider
// resolves one quotient bit per stage.

module straight_alpha_over_blend_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  sao_blend_pkg::pixel_in_t pixel_i,
  output logic                     done_o,
  output sao_blend_pkg::result_t   result_o
);
  import sao_blend_pkg::*;

  logic              busy_q;
  logic              accept;
  logic [PipeDepth-1:0] vld_q;
  logic [DenW-1:0]   den;
  alpha_info_t       alpha_info;
  logic [ChanW-1:0]  red;
  logic [ChanW-1:0]  green;
  logic [ChanW-1:0]  blue;
  result_t           res_d;
  result_t           res_q;
  logic              done_q;

  // The pipeline never stalls; busy only covers reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign accept = start & ~busy_q;
  assign busy   = busy_q;

  // Valid bits travel alongside the lane stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeDepth-2:0], accept};
    end
  end

  // Blended alpha and the shared divisor.
  sao_blend_alpha u_alpha (
    .clk_i      (clk_i),
    .fg_alpha_i (pixel_i.fg_alpha),
    .bg_alpha_i (pixel_i.bg_alpha),
    .den_o      (den),
    .info_o     (alpha_info)
  );

  // One lane per color channel, all working on the same pixel.
  sao_blend_lane u_lane_red (
    .clk_i      (clk_i),
    .fg_chan_i  (pixel_i.fg_red),
    .fg_alpha_i (pixel_i.fg_alpha),
    .bg_chan_i  (pixel_i.bg_red),
    .bg_alpha_i (pixel_i.bg_alpha),
    .den_i      (den),
    .chan_o     (red)
  );

  sao_blend_lane u_lane_green (
    .clk_i      (clk_i),
    .fg_chan_i  (pixel_i.fg_green),
    .fg_alpha_i (pixel_i.fg_alpha),
    .bg_chan_i  (pixel_i.bg_green),
    .bg_alpha_i (pixel_i.bg_alpha),
    .den_i      (den),
    .chan_o     (green)
  );

  sao_blend_lane u_lane_blue (
    .clk_i      (clk_i),
    .fg_chan_i  (pixel_i.fg_blue),
    .fg_alpha_i (pixel_i.fg_alpha),
    .bg_chan_i  (pixel_i.bg_blue),
    .bg_alpha_i (pixel_i.bg_alpha),
    .den_i      (den),
    .chan_o     (blue)
  );

  // Merge stage. With a blended alpha of zero the divisor is zero as well,
  // so the lanes report saturation; the pixel is forced to zero here.
  always_comb begin
    if (alpha_info.zero) begin
      res_d = '0;
    end else begin
      res_d.out_red   = red;
      res_d.out_green = green;
      res_d.out_blue  = blue;
      res_d.out_alpha = alpha_info.alpha;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[PipeDepth-1];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // A transparent result must be black.
  a_zero_alpha_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.out_alpha == '0) |->
      (res_q.out_red == '0 && res_q.out_green == '0 && res_q.out_blue == '0))
    else $error("zero blended alpha with nonzero color");

  // Once out of reset the block never refuses a transfer again.
  a_busy_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |=> !busy_q)
    else $error("busy rose after reset");

  // The first valid bit tracks exactly the accepted transfers.
  a_valid_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] == $past(accept))
    else $error("pipeline valid does not match accepted transfer");

endmodule

`default_nettype wire

/* hw/rtl/sao_blend_alpha.sv */
`default_nettype none

module sao_blend_alpha (
  input  logic                             clk_i,
  input  logic [sao_blend_pkg::ChanW-1:0]  fg_alpha_i,
  input  logic [sao_blend_pkg::ChanW-1:0]  bg_alpha_i,
  output logic [sao_blend_pkg::DenW-1:0]   den_o,
  output sao_blend_pkg::alpha_info_t       info_o
);
  import sao_blend_pkg::*;

  logic [2*ChanW-1:0] t_q;
  logic [ChanW-1:0]   fa_q;
  logic [ChanW-1:0]   oa_q;
  logic [DenW-1:0]    den_q;
  logic [ChanW-1:0]   oa_dly_q [AlphaDelay];

  always_ff @(posedge clk_i) begin
    t_q  <= (2*ChanW)'(bg_alpha_i) * (2*ChanW)'(FullScale - fg_alpha_i);
    fa_q <= fg_alpha_i;
    // The sum never exceeds 255.
    oa_q <= fa_q + div255(t_q);
    den_q <= (DenW'(oa_q) << ChanW) - DenW'(oa_q);
    oa_dly_q[0] <= oa_q;
  end

  for (genvar i = 1; i < AlphaDelay; i++) begin : g_dly
    always_ff @(posedge clk_i) begin
      oa_dly_q[i] <= oa_dly_q[i-1];
    end
  end

  assign den_o        = den_q;
  assign info_o.alpha = oa_dly_q[AlphaDelay-1];
  assign info_o.zero  = (oa_dly_q[AlphaDelay-1] == '0);

endmodule

`default_nettype wire

/* hw/rtl/sao_blend_lane.sv */
`default_nettype none

module sao_blend_lane (
  input  logic                             clk_i,
  input  logic [sao_blend_pkg::ChanW-1:0]  fg_chan_i,
  input  logic [sao_blend_pkg::ChanW-1:0]  fg_alpha_i,
  input  logic [sao_blend_pkg::ChanW-1:0]  bg_chan_i,
  input  logic [sao_blend_pkg::ChanW-1:0]  bg_alpha_i,
  input  logic [sao_blend_pkg::DenW-1:0]   den_i,
  output logic [sao_blend_pkg::ChanW-1:0]  chan_o
);
  import sao_blend_pkg::*;

  logic [2*ChanW-1:0] pf_q;
  logic [2*ChanW-1:0] pb_q;
  logic [ChanW-1:0]   inv_q;
  logic [NumW-1:0]    num_d;
  logic [NumW-1:0]    num_q;
  logic [NumW-1:0]    num_dly_q;

  logic [NumW-1:0]    rem_q [DivSteps];
  logic [DenW-1:0]    dd_q  [DivSteps];
  logic [ChanW-1:0]   quo_q [DivSteps+1];
  logic               sat_q [DivSteps+1];

  assign num_d = ((NumW'(pf_q) << ChanW) - NumW'(pf_q)) + (NumW'(pb_q) * NumW'(inv_q));

  always_ff @(posedge clk_i) begin
    pf_q      <= (2*ChanW)'(fg_chan_i) * (2*ChanW)'(fg_alpha_i);
    pb_q      <= (2*ChanW)'(bg_chan_i) * (2*ChanW)'(bg_alpha_i);
    inv_q     <= FullScale - fg_alpha_i;
    num_q     <= num_d;
    num_dly_q <= num_q;
    // A quotient of 256 or more saturates; otherwise eight bits are exact.
    sat_q[0]  <= (num_dly_q >= NumW'({den_i, {ChanW{1'b0}}}));
    rem_q[0]  <= num_dly_q;
    dd_q[0]   <= den_i;
    quo_q[0]  <= '0;
  end

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    logic [NumW-1:0] trial;
    logic            ge;

    assign trial = NumW'(dd_q[s]) << (DivSteps - 1 - s);
    assign ge    = (rem_q[s] >= trial);

    always_ff @(posedge clk_i) begin
      quo_q[s+1] <= {quo_q[s][ChanW-2:0], ge};
      sat_q[s+1] <= sat_q[s];
    end

    if (s < DivSteps - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        rem_q[s+1] <= ge ? (rem_q[s] - trial) : rem_q[s];
        dd_q[s+1]  <= dd_q[s];
      end
    end
  end

  assign chan_o = sat_q[DivSteps] ? FullScale : quo_q[DivSteps];

endmodule

`default_nettype wire

/* tb/sv/straight_alpha_over_blend_unit_tb.sv */
`timescale 1ns / 1ps

module straight_alpha_over_blend_unit_tb;

  import sao_blend_pkg::*;

  // Generous cycle budget, well above the slowest correct run (every pixel
  // behind the longest idle gap, plus reset and pipeline drain).
  localparam int unsigned CycleLimit = 200000;

  // After the last result the bench keeps watching for a while longer to catch
  // stray strobes.
  localparam int unsigned DrainCycles = 3 * PipeDepth;

  localparam int unsigned RandomPixels = 1950;

  logic      clk_i;
  logic      rst_ni  = 1'b0;
  logic      start   = 1'b0;
  logic      busy;
  pixel_in_t pixel_i = '0;
  logic      done_o;
  result_t   result_o;

  // Blended pixels predicted for accepted transfers, oldest first.
  result_t     pending_blends[$];
  int unsigned mismatches     = 0;
  int unsigned pixels_sent    = 0;
  int unsigned blends_checked = 0;
  int unsigned zero_alpha_cnt = 0;
  int unsigned saturated_cnt  = 0;
  int unsigned cycle_cnt      = 0;

  straight_alpha_over_blend_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .pixel_i  (pixel_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // One color channel of the over operator: the alpha-weighted average of
  // the foreground and background colors, floored, then clamped at full
  // scale. The clamp matters because the blended alpha is itself floored, so
  // the divisor can come out a little small and push the quotient past 255.
  function automatic logic [ChanW-1:0] over_channel(input logic [ChanW-1:0] fc,
                                                    input logic [ChanW-1:0] fa,
                                                    input logic [ChanW-1:0] bc,
                                                    input logic [ChanW-1:0] ba,
                                                    input int unsigned oa);
    int unsigned weighted_sum;
    int unsigned divisor;
    int unsigned quotient;
    weighted_sum = fc * fa * 255 + bc * ba * (255 - fa);
    divisor      = 255 * oa;
    quotient     = weighted_sum / divisor;
    if (quotient > 255) begin
      quotient = 255;
    end
    return quotient[ChanW-1:0];
  endfunction

  // Full over-composite of one pixel pair with straight alpha.
  function automatic result_t composite_over(input pixel_in_t px);
    result_t     blended;
    int unsigned oa;
    oa = px.fg_alpha + (px.bg_alpha * (255 - px.fg_alpha)) / 255;
    blended = '0;
    // Both alphas zero: nothing is covered, so the whole pixel is zero.
    if (oa != 0) begin
      blended.out_red   = over_channel(px.fg_red, px.fg_alpha, px.bg_red, px.bg_alpha, oa);
      blended.out_green = over_channel(px.fg_green, px.fg_alpha, px.bg_green, px.bg_alpha,
                                       oa);
      blended.out_blue  = over_channel(px.fg_blue, px.fg_alpha, px.bg_blue, px.bg_alpha, oa);
      blended.out_alpha = oa[ChanW-1:0];
    end
    return blended;
  endfunction

  task automatic report_field(input string field, input logic [ChanW-1:0] expected,
                              input logic [ChanW-1:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, expected, actual);
      mismatches++;
    end
  endtask

  // Scoreboard. Everything is sampled at the rising edge, where the block's
  // outputs still hold their pre-edge values. A result strobe is compared
  // against the oldest prediction first; then, if a transfer completes on
  // this edge, its prediction joins the queue. As the pipeline is registered,
  // a result can never belong to a transfer from the same edge.
  always @(posedge clk_i) begin
    result_t expected_blend;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_blends.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, result_o);
          mismatches++;
        end else begin
          expected_blend = pending_blends.pop_front();
          report_field("out_red", expected_blend.out_red, result_o.out_red);
          report_field("out_green", expected_blend.out_green, result_o.out_green);
          report_field("out_blue", expected_blend.out_blue, result_o.out_blue);
          report_field("out_alpha", expected_blend.out_alpha, result_o.out_alpha);
          blends_checked++;
        end
      end
      if (start && !busy) begin
        expected_blend = composite_over(pixel_i);
        pending_blends.push_back(expected_blend);
        pixels_sent++;
        if (expected_blend.out_alpha == 0) begin
          zero_alpha_cnt++;
        end
        if (expected_blend.out_red == 8'd255 || expected_blend.out_green == 8'd255 ||
            expected_blend.out_blue == 8'd255) begin
          saturated_cnt++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_cnt,
               pending_blends.size());
      $display("straight_alpha_over_blend_unit regression: fail");
      $finish;
    end
  end

  // Presents one pixel pair and holds it until the block takes it. start is
  // left high on return, so a following call continues the burst without the
  // strobe dropping; only pause_sender and the final drain lower it.
  task automatic send_pixel(input pixel_in_t px);
    start   <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic pixel_in_t make_pixel(input logic [ChanW-1:0] fr, input logic [ChanW-1:0] fg,
                                           input logic [ChanW-1:0] fb, input logic [ChanW-1:0] fa,
                                           input logic [ChanW-1:0] br, input logic [ChanW-1:0] bg,
                                           input logic [ChanW-1:0] bb, input logic [ChanW-1:0] ba);
    pixel_in_t px;
    px.fg_red   = fr;
    px.fg_green = fg;
    px.fg_blue  = fb;
    px.fg_alpha = fa;
    px.bg_red   = br;
    px.bg_green = bg;
    px.bg_blue  = bb;
    px.bg_alpha = ba;
    return px;
  endfunction

  // Random alpha, skewed toward the interesting corners: fully transparent,
  // fully opaque, and very small values where the floored alpha makes the
  // channel quotient overshoot.
  function automatic logic [ChanW-1:0] pick_alpha();
    case ($urandom_range(0, 7))
      0: begin
        return 8'd0;
      end
      1: begin
        return FullScale;
      end
      2, 3: begin
        return 8'($urandom_range(1, 4));
      end
      default: begin
        return 8'($urandom);
      end
    endcase
  endfunction

  function automatic logic [ChanW-1:0] pick_color();
    case ($urandom_range(0, 9))
      0: begin
        return 8'd0;
      end
      1, 2: begin
        return FullScale;
      end
      default: begin
        return 8'($urandom);
      end
    endcase
  endfunction

  // Corner cases: both alphas zero, each alpha at its extremes, the
  // saturating quotient, and bit patterns that toggle every input bit.
  task automatic test_corner_pixels();
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    // Zero blended alpha with bright colors must still give a zero pixel.
    send_pixel(make_pixel(8'd255, 8'd128, 8'd1, 8'd0, 8'd200, 8'd100, 8'd50, 8'd0));
    // Opaque foreground hides the background entirely.
    send_pixel(make_pixel(8'd12, 8'd34, 8'd56, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    // Transparent foreground passes the background through.
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd78, 8'd90, 8'd123, 8'd255));
    send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 8'd0, 8'd9, 8'd8, 8'd7, 8'd1));
    // Tiny alphas: the floored alpha leaves the quotient above full scale.
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd1, 8'd255, 8'd255, 8'd255, 8'd1));
    send_pixel(make_pixel(8'd255, 8'd200, 8'd254, 8'd2, 8'd255, 8'd250, 8'd253, 8'd3));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd1, 8'd255, 8'd0, 8'd255, 8'd254));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd254, 8'd0, 8'd0, 8'd0, 8'd1));
    send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA));
    send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55));
    send_pixel(make_pixel(8'd128, 8'd64, 8'd32, 8'd128, 8'd16, 8'd8, 8'd4, 8'd200));
    send_pixel(make_pixel(8'd1, 8'd2, 8'd3, 8'd127, 8'd250, 8'd251, 8'd252, 8'd129));
    pause_sender(1);
  endtask

  // Random pixels in bursts. Burst lengths range from single transfers to
  // long back-to-back stretches, and idle gaps between bursts land on every
  // stage of the 13-deep pipeline.
  task automatic test_random_pixels(input int unsigned count);
    int unsigned sent;
    int unsigned burst_len;
    sent = 0;
    while (sent < count) begin
      burst_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (burst_len) begin
        if (sent < count) begin
          send_pixel(make_pixel(pick_color(), pick_color(), pick_color(), pick_alpha(),
                                pick_color(), pick_color(), pick_color(), pick_alpha()));
          sent++;
        end
      end
      pause_sender($urandom_range(1, PipeDepth + 2));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_pixels();
    test_random_pixels(RandomPixels);

    // Drain: wait for every prediction to be matched, then keep watching so
    // that a late extra strobe is still caught. The watchdog bounds the wait.
    start <= 1'b0;
    while (pending_blends.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Composited %0d pixel pairs and checked %0d blends in %0d cycles;",
             pixels_sent, blends_checked, cycle_cnt);
    $display("%0d had zero blended alpha and %0d had at least one channel at full scale.",
             zero_alpha_cnt, saturated_cnt);
    if (mismatches == 0 && pending_blends.size() == 0) begin
      $display("straight_alpha_over_blend_unit regression: pass");
    end else begin
      $display("straight_alpha_over_blend_unit regression: fail");
    end
    $finish;
  end

endmodule
